/* sv/jtd_pkg.sv */
// Shared types and constants of the joystick throttle deadband unit.
package jtd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CENTER_W   = 12;
  localparam int DB_W       = 16;
  localparam int LEVEL_W    = 16;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CENTER_W-1:0] CENTER_RESET   = 12'd2048;
  localparam logic [DB_W-1:0]     DEADBAND_RESET = 16'd3277;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX      = 16'hFFFF;

  // two quotient bits per divider step
  localparam int DIV_STEPS = LEVEL_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER   = 2'd0,
    REG_DEADBAND = 2'd1
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NEUTRAL  = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic check;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic early;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/jtd_in_if.sv */
// Sample channel: valid/ready handshake carrying one raw ADC sample.
interface jtd_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

/* sv/jtd_out_if.sv */
// Reading channel: valid/ready handshake carrying throttle level and direction.
interface jtd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] throttle_level;
  logic [1:0]  stick_direction;

  modport source (output valid, output throttle_level, output stick_direction, input ready);
  modport sink   (input valid, input throttle_level, input stick_direction, output ready);
endinterface

/* sv/jtd_ctrl.sv */
// Sequencer: sample accumulation, multiply, deadband check, divide, result load.
module jtd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jtd_pkg::dp_stat_t stat,
  output jtd_pkg::ctl_cmd_t cmd
);
  import jtd_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_ACC: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.last_sample) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.check = 1'b1;
        step_nxt  = '0;
        state_nxt = stat.early ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

endmodule

/* sv/jtd_datapath.sv */
// Datapath: config registers, sample sum, deviation, deadband test, divider, output register.
module jtd_datapath #(
  parameter int SAMPLES_PER_READING = 10,
  parameter int ADC_BITS            = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jtd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jtd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [jtd_pkg::SAMPLE_W-1:0]        sample,
  input  jtd_pkg::ctl_cmd_t                   cmd,
  output jtd_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [jtd_pkg::LEVEL_W-1:0]         out_level,
  output logic [jtd_pkg::DIR_W-1:0]           out_dir
);
  import jtd_pkg::*;

  localparam int KEEP_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << KEEP_BITS) - 33'd1);
  localparam int SUM_W  = $clog2(SAMPLES_PER_READING * ((1 << CENTER_W) - 1) + 1);
  localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
  localparam int PROD_W = DB_W + SUM_W;

  logic [CENTER_W-1:0] center_r;
  logic [DB_W-1:0]     db_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    s_r, c_r, d_r, rem_r, rem_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic                fwd_r;
  logic [LEVEL_W-1:0]  quo_r, quo_nxt;
  dir_t                dir_r, dir_nxt;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_level_r;
  dir_t                out_dir_r;

  // deadband / early decision
  logic               c_zero, in_band, early;
  logic [LEVEL_W-1:0] early_level;
  dir_t               early_dir;

  // divider step (two restoring iterations)
  logic [SUM_W:0] t1, t2;
  logic [SUM_W-1:0] r1;
  logic           b1, b0;

  assign sum_nxt = sum_r + SUM_W'(sample & SAMPLE_MASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= CENTER_RESET;
      db_r        <= DEADBAND_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER:   center_r <= cfg_wdata[CENTER_W-1:0];
          REG_DEADBAND: db_r     <= cfg_wdata[DB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (stat.last_sample) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.load_out)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    c_zero      = (c_r == '0);
    in_band     = {d_r, 16'b0} < prod_r;
    early       = 1'b1;
    early_level = '0;
    early_dir   = DIR_NEUTRAL;
    if (c_zero) begin
      if (s_r != '0) begin
        early_level = LEVEL_MAX;
        early_dir   = DIR_FORWARD;
      end
    end else if (in_band || d_r == '0) begin
      early_level = '0;
    end else if (d_r >= c_r) begin
      // quotient would reach one full scale or more
      early_level = LEVEL_MAX;
      early_dir   = fwd_r ? DIR_FORWARD : DIR_BACKWARD;
    end else begin
      early = 1'b0;
    end
  end

  always_comb begin
    t1 = {rem_r, 1'b0};
    b1 = (t1 >= {1'b0, c_r});
    r1 = b1 ? SUM_W'(t1 - {1'b0, c_r}) : t1[SUM_W-1:0];
    t2 = {r1, 1'b0};
    b0 = (t2 >= {1'b0, c_r});
    rem_nxt = b0 ? SUM_W'(t2 - {1'b0, c_r}) : t2[SUM_W-1:0];
  end

  always_comb begin
    quo_nxt = quo_r;
    dir_nxt = dir_r;
    if (cmd.check) begin
      quo_nxt = early ? early_level : '0;
      dir_nxt = early ? early_dir : (fwd_r ? DIR_FORWARD : DIR_BACKWARD);
    end else if (cmd.div_step) begin
      quo_nxt = {quo_r[LEVEL_W-3:0], b1, b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.last_sample) begin
      s_r <= sum_nxt;
      c_r <= SUM_W'(SAMPLES_PER_READING) * SUM_W'(center_r);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(db_r) * PROD_W'(c_r);
      fwd_r  <= s_r > c_r;
      d_r    <= (s_r > c_r) ? (s_r - c_r) : (c_r - s_r);
    end
    if (cmd.check) rem_r <= d_r;
    else if (cmd.div_step) rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dir_r <= dir_nxt;
    if (cmd.load_out) begin
      out_level_r <= quo_r;
      out_dir_r   <= dir_r;
    end
  end

  assign stat.last_sample = (cnt_r == CNT_W'(SAMPLES_PER_READING - 1));
  assign stat.early       = early;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_dir   = out_dir_r;

endmodule

/* sv/joystick_throttle_deadband_unit.sv */
// Throttle unit: averages groups of samples and reports deviation past a center deadband.
// Samples are taken one per cycle while no reading is in flight; the last sample of a group
// starts a reading: multiply, deadband check, then straight to the output
// (neutral or saturated) or first through the two-bit-per-cycle restoring divider (8 steps).
// Input is held off only while a reading is in flight; the output register lets it proceed.
// Reset (synchronous, rst_n low) clears sum, count and output valid; center 2048, deadband 3277.
module joystick_throttle_deadband_unit #(
  parameter int SAMPLES_PER_READING = 10,
  parameter int ADC_BITS            = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  jtd_in_if.sink                         in_chan,
  jtd_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [jtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jtd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import jtd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  jtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jtd_datapath #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .ADC_BITS            (ADC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample    (in_chan.adc_sample),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_level (out_chan.throttle_level),
    .out_dir   (out_chan.stick_direction)
  );

endmodule

/* bench/tb.sv */
// Testbench for the joystick throttle deadband unit: directed groups, then random phases.
module tb;
  import jtd_pkg::*;

  localparam int GROUP_LEN     = 10;
  localparam int TOTAL_SAMPLES = 1150;
  localparam int QUIET_FROM    = 1000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int N_DIRECTED    = 7;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 2'd3;

  typedef enum int {
    GEN_UNIFORM,
    GEN_NEAR_CENTER,
    GEN_AT_CENTER,
    GEN_EXTREMES
  } group_gen_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    dir_t               dir;
  } reading_t;

  typedef struct packed {
    bit                    set_cfg;
    bit                    spare_wr;
    logic [CFG_DATA_W-1:0] center_wd;
    logic [CFG_DATA_W-1:0] deadband_wd;
    logic [SAMPLE_W-1:0]   sample;
    bit                    typed;
    reading_t              want;
  } group_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  jtd_in_if  in_if ();
  jtd_out_if out_if ();

  joystick_throttle_deadband_unit #(
    .SAMPLES_PER_READING(GROUP_LEN),
    .ADC_BITS(SAMPLE_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [CENTER_W-1:0] cur_center;
  logic [DB_W-1:0]     cur_deadband;
  logic [15:0]         acc_sum;
  int                  acc_count;

  reading_t   readings_due[$];
  group_row_t directed_rows [N_DIRECTED];

  int mismatch_count = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int ready_hold = 0;
  bit quiet = 1'b0;

  // Adds one sample to the running group; returns 1 with the reading on the last one.
  function automatic bit fold_sample(input logic [SAMPLE_W-1:0] v, output reading_t r);
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] q;
    r.level = '0;
    r.dir = DIR_NEUTRAL;
    acc_sum = acc_sum + 16'(v);
    acc_count++;
    if (acc_count < GROUP_LEN) return 1'b0;
    c = 64'(GROUP_LEN) * 64'(cur_center);
    s = 64'(acc_sum);
    d = (s > c) ? s - c : c - s;
    if (c == 0) begin
      // zero center: any positive sum is full forward
      if (s != 0) begin
        r.level = LEVEL_MAX;
        r.dir = DIR_FORWARD;
      end
    end else if ((d << 16) < 64'(cur_deadband) * c) begin
      r.dir = DIR_NEUTRAL;
    end else if (d != 0) begin
      q = (d << 16) / c;
      r.level = (q > 64'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_W-1:0];
      r.dir = (s > c) ? DIR_FORWARD : DIR_BACKWARD;
    end
    acc_sum = '0;
    acc_count = 0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(99) >= idle_pct) return 0;
    return $urandom_range(1, 14);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input int gap, input bit typed,
                             input reading_t typed_want);
    reading_t r;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.adc_sample <= v;
    do @(posedge clk); while (!in_if.ready);
    samples_sent++;
    if (fold_sample(v, r)) readings_due.push_back(typed ? typed_want : r);
  endtask

  // drop valid and let every reading drain before touching registers
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CENTER) cur_center = data[CENTER_W-1:0];
    else if (idx == REG_DEADBAND) cur_deadband = data[DB_W-1:0];
  endtask

  function automatic logic [SAMPLE_W-1:0] gen_sample(input group_gen_t gen, input int spread);
    int v;
    int off;
    case (gen)
      GEN_NEAR_CENTER: begin
        off = $urandom_range(0, spread);
        v = $urandom_range(1) ? int'(cur_center) + off : int'(cur_center) - off;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      GEN_AT_CENTER: v = int'(cur_center);
      GEN_EXTREMES: v = $urandom_range(1) ? 4095 : 0;
      default: v = $urandom_range(0, 4095);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_if.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!quiet && $urandom_range(99) < stall_pct) begin
      out_if.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 13);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reading_t due;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (readings_due.size() == 0) begin
        $error("reading with none due: throttle_level=%0d stick_direction=%0d",
               out_if.throttle_level, out_if.stick_direction);
        mismatch_count++;
      end else begin
        due = readings_due.pop_front();
        if (out_if.throttle_level !== due.level) begin
          $error("throttle_level: expected %0d, got %0d", due.level, out_if.throttle_level);
          mismatch_count++;
        end
        if (out_if.stick_direction !== due.dir) begin
          $error("stick_direction: expected %0d, got %0d", due.dir, out_if.stick_direction);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    group_gen_t            gen;
    int                    groups;
    int                    spread;
    logic [CFG_DATA_W-1:0] wd;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.adc_sample = '0;
    out_if.ready = 1'b0;
    cur_center = CENTER_RESET;
    cur_deadband = DEADBAND_RESET;
    acc_sum = '0;
    acc_count = 0;

    // set_cfg, spare_wr, center, deadband, sample, typed, expected reading
    directed_rows = '{
      // reset values, sum right on center
      '{1'b0, 1'b0, 16'd0, 16'd0, 12'd2048, 1'b1, '{16'd0, DIR_NEUTRAL}},
      // zero deadband with exact match stays neutral
      '{1'b1, 1'b0, 16'd2048, 16'd0, 12'd2048, 1'b1, '{16'd0, DIR_NEUTRAL}},
      // upper data bits dropped: center reads zero, zero sum
      '{1'b1, 1'b0, 16'hF000, 16'd3277, 12'd0, 1'b1, '{16'd0, DIR_NEUTRAL}},
      // zero center with positive sum
      '{1'b1, 1'b0, 16'h0000, 16'd3277, 12'd4095, 1'b1, '{LEVEL_MAX, DIR_FORWARD}},
      // smallest center, full scale: saturates; unused indexes must not land
      '{1'b1, 1'b1, 16'd1, 16'd0, 12'd4095, 1'b1, '{LEVEL_MAX, DIR_FORWARD}},
      // largest center and deadband, zero input: ratio of one saturates
      '{1'b1, 1'b0, 16'd4095, 16'hFFFF, 12'd0, 1'b1, '{LEVEL_MAX, DIR_BACKWARD}},
      '{1'b1, 1'b0, 16'd2048, 16'd3277, 12'd3000, 1'b0, '{16'd0, DIR_NEUTRAL}}
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 15;
    stall_pct = 15;
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].set_cfg) begin
        settle();
        write_reg(REG_CENTER, directed_rows[i].center_wd);
        write_reg(REG_DEADBAND, directed_rows[i].deadband_wd);
        if (directed_rows[i].spare_wr) begin
          write_reg(REG_NONE_LO, 16'hFFFF);
          write_reg(REG_NONE_HI, 16'h0000);
        end
      end
      for (int k = 0; k < GROUP_LEN; k++)
        send_sample(directed_rows[i].sample, pick_gap(), directed_rows[i].typed,
                    directed_rows[i].want);
    end

    while (samples_sent < TOTAL_SAMPLES) begin
      settle();
      quiet = (samples_sent >= QUIET_FROM);
      idle_pct = pick_pct();
      stall_pct = pick_pct();

      wd = 16'($urandom());
      case ($urandom_range(9))
        0: wd[11:0] = 12'd1;
        1: wd[11:0] = 12'd4095;
        2: wd[11:0] = 12'd2048;
        3: wd[11:0] = ($urandom_range(3) == 0) ? 12'd0 : 12'd1;
        default: wd[11:0] = 12'($urandom_range(1, 4095));
      endcase
      write_reg(REG_CENTER, wd);
      case ($urandom_range(7))
        0: wd = 16'd0;
        1: wd = 16'hFFFF;
        2, 3, 4: wd = 16'($urandom_range(0, 8000));
        default: wd = 16'($urandom());
      endcase
      write_reg(REG_DEADBAND, wd);
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? REG_NONE_LO : REG_NONE_HI, 16'($urandom()));

      groups = $urandom_range(1, 6);
      for (int g = 0; g < groups; g++) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5: gen = GEN_UNIFORM;
          6, 7, 8: gen = GEN_AT_CENTER;
          9, 10, 11: gen = GEN_EXTREMES;
          default: gen = GEN_NEAR_CENTER;
        endcase
        case ($urandom_range(2))
          0: spread = 2;
          1: spread = 20;
          default: spread = 200;
        endcase
        for (int k = 0; k < GROUP_LEN; k++)
          send_sample(gen_sample(gen, spread), pick_gap(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
